[design/egsu_pkg.sv]
// Shared types, constants and helpers for the elevation grid splat update block.
// Depends on nothing; every other design file but egsu_ram imports it.
`default_nettype none

package egsu_pkg;

   // Grid geometry
   localparam int GRID_HALF  = 256;
   localparam int MAX_RADIUS = 8;
   localparam int GRID_SIDE  = 2 * GRID_HALF;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int AXW        = $clog2(GRID_SIDE);     // bits per grid axis
   localparam int ADDR_W     = 2 * AXW;               // cell store address
   localparam int RAD_W      = (MAX_RADIUS < 1) ? 1 : $clog2(MAX_RADIUS + 1);
   localparam int SQ_W       = 2 * RAD_W + 4;         // squared distance sums
   localparam int CRD_W      = 22;                    // signed cell coordinates
   localparam int ROI_W      = 9;                     // reported box coordinate width
   localparam int CELL_W     = 24;                    // height + confidence

   // Action codes
   localparam logic [1:0] ACT_SPLAT = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Confidence value that selects the square footprint
   localparam logic [7:0] SQUARE_CONF = 8'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_PER_MM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 2'd2;

   // Configuration reset values
   localparam logic [15:0] CELLS_PER_MM_RESET = 16'd1311;
   localparam logic [8:0]  ORIGIN_X_RESET     = 9'd256;
   localparam logic [8:0]  ORIGIN_Y_RESET     = 9'd256;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [19:0] world_x_mm;
      logic signed [19:0] world_y_mm;
      logic signed [15:0] height_mm;
      logic [7:0]         confidence;
      logic [15:0]        radius_mm;
      logic               clear_box;
      logic [8:0]         read_cell_x;
      logic [8:0]         read_cell_y;
   } req_type;

   typedef struct packed {
      logic               was_updated;
      logic [8:0]         roi_min_x;
      logic [8:0]         roi_max_x;
      logic [8:0]         roi_min_y;
      logic [8:0]         roi_max_y;
      logic signed [15:0] cell_height;
      logic [7:0]         cell_confidence;
   } rsp_type;

   typedef struct packed {
      logic [15:0] cells_per_mm_q16;
      logic [8:0]  origin_cell_x;
      logic [8:0]  origin_cell_y;
   } cfg_type;

   // Footprint geometry of one splat, from the coordinate unit
   typedef struct packed {
      logic [CRD_W-1:0]   cx;       // two's complement
      logic [CRD_W-1:0]   cy;
      logic [RAD_W-1:0]   r;
      logic [2*RAD_W-1:0] rsq;
      logic signed [15:0] h;
      logic [7:0]         conf;
      logic               square;
   } geom_type;

   typedef struct packed {
      logic signed [15:0] height;
      logic [7:0]         conf;
   } cell_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_READ,
      ST_DONE
   } state_type;

   // Grid coordinate to the 9-bit reported width (masked or zero-extended)
   function automatic logic [ROI_W-1:0] to_roi(input logic [AXW-1:0] v);
      logic [AXW+ROI_W-1:0] w;
      w = (AXW + ROI_W)'(v);
      return w[ROI_W-1:0];
   endfunction

endpackage

`default_nettype wire

[design/elevation_grid_splat_update.sv]
// Splat: states MUL, PREP, then a scan of the (2r+1)^2 footprint positions (r the
//   saturated cell radius, at most 8), DRAIN, DONE; query: DONE; cell read: READ, DONE.
// Throughput: one transaction at a time; a splat is bound by the one-cell-per-cycle
//   read-modify-write of the cell store, and a new request waits for idle.
// Reset: synchronous; a clearing pass then zeroes all 262144 cells, one per cycle,
//   with req_stall high; configuration writes are taken throughout.
`default_nettype none

module elevation_grid_splat_update import egsu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   logic       slot_free;
   logic       push;
   rsp_type    result;
   req_type    item;
   geom_type   geom;
   ram_wr_type ram_wr;
   ram_rd_type ram_rd;
   logic [CELL_W-1:0] rd_word;
   cell_type   rd_cell;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CELLS_PER_MM: cfg_in.cells_per_mm_q16 = csr_wdata;
            CSR_ORIGIN_X:     cfg_in.origin_cell_x    = csr_wdata[8:0];
            CSR_ORIGIN_Y:     cfg_in.origin_cell_y    = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_per_mm_q16 <= CELLS_PER_MM_RESET;
         cfg_ff.origin_cell_x    <= ORIGIN_X_RESET;
         cfg_ff.origin_cell_y    <= ORIGIN_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register: frees the sequencer while a result waits
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = push || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Units
   egsu_coord u_coord (
      .clock (clock),
      .item  (item),
      .cfg   (cfg_ff),
      .geom  (geom)
   );

   egsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .slot_free (slot_free),
      .push      (push),
      .result    (result),
      .item      (item),
      .geom      (geom),
      .ram_wr    (ram_wr),
      .ram_rd    (ram_rd),
      .rd_cell   (rd_cell)
   );

   // Cell store: height and confidence side by side
   egsu_ram #(
      .WIDTH (CELL_W),
      .DEPTH (GRID_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (rd_word)
   );

   assign rd_cell = rd_word;

endmodule

`default_nettype wire

[design/egsu_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package dependency.
`default_nettype none

module egsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/egsu_coord.sv]
// Coordinate unit: world mm to cell centre, cell radius and negated height.
// Two register stages (products, then rounding/saturation). Uses egsu_pkg.
`default_nettype none

module egsu_coord import egsu_pkg::*; (
   input  logic     clock,
   input  req_type  item,
   input  cfg_type  cfg,
   output geom_type geom
);

   logic signed [36:0] prod_x_ff, prod_x_in;
   logic signed [36:0] prod_y_ff, prod_y_in;
   logic [31:0]        rad_prod_ff, rad_prod_in;
   logic signed [15:0] h_neg_ff, h_neg_in;
   logic [7:0]         conf_ff;
   geom_type           geom_ff, geom_in;

   logic signed [36:0] rnd_x, rnd_y;
   logic [20:0]        cell_x, cell_y;
   logic [15:0]        rr;
   logic [RAD_W-1:0]   r;
   logic [2*RAD_W-1:0] r_w;

   // Stage 1: position and radius products, height negation (saturating)
   always_comb begin
      prod_x_in   = $signed(item.world_x_mm) * $signed({1'b0, cfg.cells_per_mm_q16});
      prod_y_in   = $signed(item.world_y_mm) * $signed({1'b0, cfg.cells_per_mm_q16});
      rad_prod_in = item.radius_mm * cfg.cells_per_mm_q16;
      if (item.height_mm == 16'sh8000) begin
         h_neg_in = 16'sh7FFF;
      end else begin
         h_neg_in = -item.height_mm;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      rad_prod_ff <= rad_prod_in;
      h_neg_ff    <= h_neg_in;
      conf_ff     <= item.confidence;
   end

   // Stage 2: round to nearest cell (floor after half-cell bias), add origin,
   // saturate radius and square it
   always_comb begin
      rnd_x  = prod_x_ff + 37'sd32768;
      rnd_y  = prod_y_ff + 37'sd32768;
      cell_x = rnd_x[36:16];
      cell_y = rnd_y[36:16];
      rr     = rad_prod_ff[31:16];
      if (rr > 16'(MAX_RADIUS)) begin
         r = RAD_W'(MAX_RADIUS);
      end else begin
         r = rr[RAD_W-1:0];
      end
      r_w = (2 * RAD_W)'(r);

      geom_in.cx     = {{(CRD_W-21){cell_x[20]}}, cell_x} + CRD_W'(cfg.origin_cell_x);
      geom_in.cy     = {{(CRD_W-21){cell_y[20]}}, cell_y} + CRD_W'(cfg.origin_cell_y);
      geom_in.r      = r;
      geom_in.rsq    = r_w * r_w;
      geom_in.h      = h_neg_ff;
      geom_in.conf   = conf_ff;
      geom_in.square = (conf_ff == SQUARE_CONF);
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

`default_nettype wire

[design/egsu_ctrl.sv]
// Sequencer: store clearing pass, footprint scan with pipelined
// read-modify-write of the cell store, bounding box, cell read and result build.
// Uses egsu_pkg; drives the egsu_ram ports through the top level.
`default_nettype none

module egsu_ctrl import egsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  logic       slot_free,
   output logic       push,
   output rsp_type    result,
   output req_type    item,
   input  geom_type   geom,
   output ram_wr_type ram_wr,
   output ram_rd_type ram_rd,
   input  cell_type   rd_cell
);

   localparam int RW = AXW + 9;

   state_type         state_ff, state_in;
   req_type           item_ff;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [RAD_W:0]    u_dx_ff, u_dx_in;
   logic [RAD_W:0]    u_dy_ff, u_dy_in;
   logic              p_vld_ff, p_vld_in;
   logic [AXW-1:0]    p_x_ff, p_y_ff;
   logic [AXW-1:0]    box_left_ff, box_left_in;
   logic [AXW-1:0]    box_right_ff, box_right_in;
   logic [AXW-1:0]    box_top_ff, box_top_in;
   logic [AXW-1:0]    box_bottom_ff, box_bottom_in;
   logic              box_valid_ff, box_valid_in;
   logic              changed_ff, changed_in;

   logic                  accept;
   logic [RAD_W:0]        span;
   logic signed [RAD_W+1:0] dx, dy;
   logic signed [SQ_W-1:0]  dx_w, dy_w;
   logic [SQ_W-1:0]       dx_sq, dy_sq, sq_sum;
   logic [CRD_W-1:0]      x_pos, y_pos;
   logic                  in_grid, in_foot, scan_last;
   logic                  upd, clear_now;
   logic [RW-1:0]         rx_w, ry_w;
   logic                  rd_in_range;

   assign accept = req_valid && !req_stall;
   assign item   = item_ff;

   // Footprint position of the current scan step
   always_comb begin
      span      = {geom.r, 1'b0};
      dx        = $signed({1'b0, u_dx_ff}) - $signed({2'b00, geom.r});
      dy        = $signed({1'b0, u_dy_ff}) - $signed({2'b00, geom.r});
      dx_w      = SQ_W'(dx);
      dy_w      = SQ_W'(dy);
      dx_sq     = dx_w * dx_w;
      dy_sq     = dy_w * dy_w;
      sq_sum    = dx_sq + dy_sq;
      x_pos     = geom.cx + CRD_W'(dx);
      y_pos     = geom.cy + CRD_W'(dy);
      // negative coordinates wrap to huge unsigned values and fail too
      in_grid   = (x_pos < CRD_W'(GRID_SIDE)) && (y_pos < CRD_W'(GRID_SIDE));
      in_foot   = geom.square || (sq_sum <= SQ_W'(geom.rsq));
      scan_last = (u_dx_ff == span) && (u_dy_ff == span);
   end

   // Read-cell address and range check
   always_comb begin
      rx_w        = RW'(item_ff.read_cell_x);
      ry_w        = RW'(item_ff.read_cell_y);
      rd_in_range = (rx_w < RW'(GRID_SIDE)) && (ry_w < RW'(GRID_SIDE));
   end

   // Write-back decision for the cell whose read was issued in the previous cycle
   assign upd = p_vld_ff && (rd_cell.height != geom.h) && !(rd_cell.conf > geom.conf);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(GRID_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_SPLAT) begin
                  state_in = ST_MUL;
               end else if (req_data.action == ACT_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL:   state_in = ST_PREP;
         ST_PREP:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake, memory ports
   always_comb begin
      req_stall   = 1'b1;
      push        = 1'b0;
      ram_rd.en   = 1'b0;
      ram_rd.addr = {x_pos[AXW-1:0], y_pos[AXW-1:0]};
      ram_wr.en   = upd;
      ram_wr.addr = {p_x_ff, p_y_ff};
      ram_wr.data = {geom.h, geom.conf};
      p_vld_in    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_cnt_ff;
            ram_wr.data = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SCAN: begin
            ram_rd.en = in_grid && in_foot;
            p_vld_in  = in_grid && in_foot;
         end
         ST_READ: begin
            ram_rd.en   = 1'b1;
            ram_rd.addr = {rx_w[AXW-1:0], ry_w[AXW-1:0]};
         end
         ST_DONE: begin
            push = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Counters: clearing sweep and footprint scan
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      u_dx_in = '0;
      u_dy_in = '0;
      if (state_ff == ST_SCAN) begin
         if (u_dx_ff == span) begin
            u_dy_in = u_dy_ff + 1'b1;
         end else begin
            u_dx_in = u_dx_ff + 1'b1;
            u_dy_in = u_dy_ff;
         end
      end
   end

   // Bounding box and changed flag
   assign clear_now = push && (item_ff.action == ACT_QUERY) && item_ff.clear_box && changed_ff;

   always_comb begin
      box_left_in   = box_left_ff;
      box_right_in  = box_right_ff;
      box_top_in    = box_top_ff;
      box_bottom_in = box_bottom_ff;
      box_valid_in  = box_valid_ff;
      changed_in    = changed_ff;
      if (upd) begin
         if (!box_valid_ff || (p_x_ff < box_left_ff))   box_left_in   = p_x_ff;
         if (!box_valid_ff || (p_x_ff > box_right_ff))  box_right_in  = p_x_ff;
         if (!box_valid_ff || (p_y_ff < box_top_ff))    box_top_in    = p_y_ff;
         if (!box_valid_ff || (p_y_ff > box_bottom_ff)) box_bottom_in = p_y_ff;
         box_valid_in = 1'b1;
         changed_in   = 1'b1;
      end else if (clear_now) begin
         box_left_in   = '0;
         box_right_in  = '0;
         box_top_in    = '0;
         box_bottom_in = '0;
         box_valid_in  = 1'b0;
         changed_in    = 1'b0;
      end
   end

   // Result: box as it stands before any clearing, cell only on a read
   always_comb begin
      result             = '0;
      result.was_updated = changed_ff;
      if (box_valid_ff) begin
         result.roi_min_x = to_roi(box_left_ff);
         result.roi_max_x = to_roi(box_right_ff);
         result.roi_min_y = to_roi(box_top_ff);
         result.roi_max_y = to_roi(box_bottom_ff);
      end
      if ((item_ff.action == ACT_READ) && rd_in_range) begin
         result.cell_height     = rd_cell.height;
         result.cell_confidence = rd_cell.conf;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         u_dx_ff       <= '0;
         u_dy_ff       <= '0;
         p_vld_ff      <= 1'b0;
         box_left_ff   <= '0;
         box_right_ff  <= '0;
         box_top_ff    <= '0;
         box_bottom_ff <= '0;
         box_valid_ff  <= 1'b0;
         changed_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         u_dx_ff       <= u_dx_in;
         u_dy_ff       <= u_dy_in;
         p_vld_ff      <= p_vld_in;
         box_left_ff   <= box_left_in;
         box_right_ff  <= box_right_in;
         box_top_ff    <= box_top_in;
         box_bottom_ff <= box_bottom_in;
         box_valid_ff  <= box_valid_in;
         changed_ff    <= changed_in;
      end
   end

   // Payload registers: captured transaction and pending write address.
   // Every scan step hits a distinct cell, so the write of one step never
   // meets the read of the next at the same entry.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      p_x_ff <= x_pos[AXW-1:0];
      p_y_ff <= y_pos[AXW-1:0];
   end

endmodule

`default_nettype wire

[design/egsu_checker.sv]
// Port-level checks for elevation_grid_splat_update, bound to the top level.
// Uses egsu_pkg for the transaction types.
`default_nettype none

module egsu_checker import egsu_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [15:0]          csr_wdata
);

   // Reset leaves no result pending and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_stall))
      else $error("result pending or input open after reset");

   // One transaction at a time: input closes after each acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted in consecutive cycles");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // An unchanged map reports an empty box
   a_box_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.was_updated) |->
         (rsp_data.roi_min_x == '0 && rsp_data.roi_max_x == '0 &&
          rsp_data.roi_min_y == '0 && rsp_data.roi_max_y == '0))
      else $error("box reported without a change");

endmodule

bind elevation_grid_splat_update egsu_checker u_egsu_checker (.*);

`default_nettype wire

[tb/elevation_grid_splat_update_tb.sv]
// Self-checking testbench for the elevation grid splat update block: a shadow grid
// predicts every reply, directed and random transactions run under several settings.
// Depends on egsu_pkg and elevation_grid_splat_update.
`timescale 1ns / 100ps

module elevation_grid_splat_update_tb;
   import egsu_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         QUIET_LIMIT = 800000;   // must outlast the clearing pass over all 262144 cells
   localparam int         SETTLE      = 300;      // must outlast the longest splat (radius 8)

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Shadow copy of the map and its registers
   bit signed [15:0] shadow_height [GRID_CELLS];
   bit [7:0]         shadow_conf [GRID_CELLS];
   int               box_lo_x, box_hi_x, box_lo_y, box_hi_y;
   bit               box_set, map_changed;
   int               cfg_res = CELLS_PER_MM_RESET;
   int               cfg_org_x = ORIGIN_X_RESET;
   int               cfg_org_y = ORIGIN_Y_RESET;
   longint           last_splat_x = GRID_HALF, last_splat_y = GRID_HALF;

   rsp_type grid_replies_due [$];
   int      fail_count = 0;
   bit      idle_on = 1'b1;
   int      stall_left = 0;
   int      quiet_cycles = 0;

   elevation_grid_splat_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow map

   function automatic void paint_cell(longint x, longint y, int hv, logic [7:0] conf);
      int idx;
      if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE) return;
      idx = int'(x) * GRID_SIDE + int'(y);
      if (shadow_height[idx] == hv || shadow_conf[idx] > conf) return;
      shadow_height[idx] = 16'(hv);
      shadow_conf[idx]   = conf;
      if (!box_set || x < box_lo_x) box_lo_x = int'(x);
      if (!box_set || x > box_hi_x) box_hi_x = int'(x);
      if (!box_set || y < box_lo_y) box_lo_y = int'(y);
      if (!box_set || y > box_hi_y) box_hi_y = int'(y);
      box_set     = 1'b1;
      map_changed = 1'b1;
   endfunction

   // Applies one transaction to the shadow map and returns the reply it should give
   function automatic rsp_type grid_reply_for(input req_type item);
      rsp_type reply;
      longint  mm_x, mm_y, rad_mm, cx, cy, rad;
      int      hv, idx;
      reply = '0;
      if (item.action == ACT_SPLAT) begin
         mm_x   = item.world_x_mm;
         mm_y   = item.world_y_mm;
         rad_mm = item.radius_mm;
         cx  = ((mm_x * cfg_res + 32768) >>> 16) + cfg_org_x;
         cy  = ((mm_y * cfg_res + 32768) >>> 16) + cfg_org_y;
         rad = (rad_mm * cfg_res) >>> 16;
         if (rad > MAX_RADIUS) rad = MAX_RADIUS;
         hv = item.height_mm;
         hv = -hv;
         if (hv > 32767) hv = 32767;   // negating the most negative height saturates
         last_splat_x = cx;
         last_splat_y = cy;
         for (longint dy = -rad; dy <= rad; dy++)
            for (longint dx = -rad; dx <= rad; dx++)
               if (item.confidence == SQUARE_CONF || dx * dx + dy * dy <= rad * rad)
                  paint_cell(cx + dx, cy + dy, hv, item.confidence);
      end
      reply.was_updated = map_changed;
      if (box_set) begin
         reply.roi_min_x = 9'(box_lo_x);
         reply.roi_max_x = 9'(box_hi_x);
         reply.roi_min_y = 9'(box_lo_y);
         reply.roi_max_y = 9'(box_hi_y);
      end
      if (item.action == ACT_QUERY) begin
         if (item.clear_box && map_changed) begin
            box_lo_x = 0; box_hi_x = 0; box_lo_y = 0; box_hi_y = 0;
            box_set     = 1'b0;
            map_changed = 1'b0;
         end
      end else if (item.action == ACT_READ) begin
         if (item.read_cell_x < GRID_SIDE && item.read_cell_y < GRID_SIDE) begin
            idx = int'(item.read_cell_x) * GRID_SIDE + int'(item.read_cell_y);
            reply.cell_height     = shadow_height[idx];
            reply.cell_confidence = shadow_conf[idx];
         end
      end
      return reply;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_request(input req_type item);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      grid_replies_due.push_back(grid_reply_for(item));
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CELLS_PER_MM: cfg_res   = value & 'hFFFF;
         CSR_ORIGIN_X:     cfg_org_x = value & 'h1FF;
         CSR_ORIGIN_Y:     cfg_org_y = value & 'h1FF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (grid_replies_due.size() != 0);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic req_type splat_request(int x, int y, int h, int conf, int rad);
      req_type item;
      item = '0;
      item.action     = ACT_SPLAT;
      item.world_x_mm = 20'(x);
      item.world_y_mm = 20'(y);
      item.height_mm  = 16'(h);
      item.confidence = 8'(conf);
      item.radius_mm  = 16'(rad);
      return item;
   endfunction

   function automatic req_type probe_request(logic [1:0] act, logic clr, int rx, int ry);
      req_type item;
      item = '0;
      item.action      = act;
      item.clear_box   = clr;
      item.read_cell_x = 9'(rx);
      item.read_cell_y = 9'(ry);
      return item;
   endfunction

   // World position (mm) that lands on or near a chosen cell
   function automatic logic [19:0] mm_towards_cell(int target, int origin);
      logic [31:0] rnd;
      longint      v;
      rnd = $urandom;
      if (cfg_res == 0) return rnd[19:0];
      v = (longint'(target - origin) * 65536 + longint'($urandom_range(0, 65535)) - 32768)
          / cfg_res;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v[19:0];
   endfunction

   // Radius (mm) that gives roughly the chosen cell radius
   function automatic logic [15:0] mm_for_radius(int cells);
      logic [31:0] rnd;
      longint      v;
      rnd = $urandom;
      if (cfg_res == 0) return rnd[15:0];
      v = (longint'(cells) * 65536 + longint'($urandom_range(0, 65535))) / cfg_res;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic req_type random_request();
      logic [127:0] raw;
      req_type      item;
      int           pick, target, conf_pick;
      raw  = {$urandom, $urandom, $urandom, $urandom};
      item = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         item.action = ACT_SPLAT;
         // mostly aimed at the grid, the rest anywhere in the 20-bit range
         if ($urandom_range(0, 4) != 0) begin
            target = $urandom_range(0, GRID_SIDE + 15);
            item.world_x_mm = mm_towards_cell(target - 8, cfg_org_x);
            target = $urandom_range(0, GRID_SIDE + 15);
            item.world_y_mm = mm_towards_cell(target - 8, cfg_org_y);
         end
         // a small set of heights so repeats hit cells that already hold them
         if ($urandom_range(0, 1) != 0)
            item.height_mm = 16'(100 * (int'($urandom_range(0, 6)) - 3));
         conf_pick = $urandom_range(0, 9);
         if (conf_pick < 3) item.confidence = SQUARE_CONF;
         else if (conf_pick < 9) item.confidence = 8'($urandom_range(0, 7));
         if ($urandom_range(0, 2) != 0)
            item.radius_mm = mm_for_radius($urandom_range(0, MAX_RADIUS + 2));
      end else if (pick < 75) begin
         item.action = ACT_QUERY;
      end else if (pick < 95) begin
         item.action = ACT_READ;
         if ($urandom_range(0, 3) != 0) begin
            item.read_cell_x = 9'(last_splat_x + $urandom_range(0, 2 * MAX_RADIUS)
                                  - MAX_RADIUS);
            item.read_cell_y = 9'(last_splat_y + $urandom_range(0, 2 * MAX_RADIUS)
                                  - MAX_RADIUS);
         end
      end else begin
         item.action = ACT_UNUSED;
      end
      return item;
   endfunction

   // ---------------------------------------------------------------- tests

   // Registers written during the clearing pass, then an empty map is probed
   task automatic test_empty_map();
      write_register(CSR_CELLS_PER_MM, CELLS_PER_MM_RESET);
      write_register(CSR_ORIGIN_X, ORIGIN_X_RESET);
      write_register(CSR_ORIGIN_Y, ORIGIN_Y_RESET);
      send_request(probe_request(ACT_QUERY, 1'b0, 0, 0));
      send_request(probe_request(ACT_READ, 1'b0, 0, 0));
      send_request(probe_request(ACT_READ, 1'b0, 511, 511));
   endtask

   task automatic test_directed_splats();
      req_type odd;
      odd = '1;
      odd.action = ACT_UNUSED;
      send_request(splat_request(0, 0, 1000, 5, 0));            // single centre cell
      send_request(probe_request(ACT_READ, 1'b0, 256, 256));
      send_request(splat_request(0, 0, 1000, 5, 0));            // same height: no change
      send_request(splat_request(0, 0, 500, 3, 0));             // lower confidence loses
      send_request(splat_request(0, 0, -32768, 255, 0));        // negation saturates
      send_request(probe_request(ACT_READ, 1'b0, 256, 256));
      send_request(probe_request(ACT_QUERY, 1'b0, 0, 0));
      send_request(probe_request(ACT_QUERY, 1'b1, 0, 0));       // box reported then cleared
      send_request(probe_request(ACT_QUERY, 1'b1, 0, 0));       // clear with nothing changed
      // square at the low corner, saturated radius, partly off the grid
      send_request(splat_request(-12800, -12800, 32767, 2, 65535));
      send_request(probe_request(ACT_READ, 1'b0, 0, 0));
      // disk on the right edge
      send_request(splat_request(12750, 0, -1, 7, 65535));
      send_request(probe_request(ACT_READ, 1'b0, 511, 256));
      send_request(splat_request(524287, -524288, 123, 9, 100)); // far off the grid
      send_request(splat_request(2000, 2000, 0, 0, 60));         // zero height on fresh cells
      send_request(odd);
      send_request(probe_request(ACT_QUERY, 1'b1, 0, 0));
   endtask

   // Zero resolution: every splat lands on the origin cell with no radius
   task automatic test_zero_resolution();
      wait_for_replies();
      write_register(CSR_CELLS_PER_MM, 0);
      write_register(CSR_ORIGIN_X, 100);
      write_register(CSR_ORIGIN_Y, 400);
      send_request(splat_request(524287, 524287, -200, 4, 65535));
      send_request(splat_request(-524288, 77, 300, 6, 0));
      send_request(probe_request(ACT_READ, 1'b0, 100, 400));
      send_request(probe_request(ACT_QUERY, 1'b1, 0, 0));
      send_request(probe_request(ACT_READ, 1'b0, 101, 400));
   endtask

   task automatic test_random_phase(input int res, input int org_x, input int org_y,
                                    input int count);
      wait_for_replies();
      write_register(CSR_CELLS_PER_MM, res);
      write_register(CSR_ORIGIN_X, org_x);
      write_register(CSR_ORIGIN_Y, org_y);
      repeat (count) send_request(random_request());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_map();
      test_directed_splats();
      test_zero_resolution();
      test_random_phase(65535, 0, 0, 90);
      test_random_phase(65535, 511, 511, 90);
      test_random_phase(1, 0, 511, 60);
      test_random_phase($urandom_range(1, 65535), $urandom_range(0, 511),
                        $urandom_range(0, 511), 90);
      // closing stretch at full rate on both sides
      idle_on = 1'b0;
      test_random_phase(CELLS_PER_MM_RESET, ORIGIN_X_RESET, ORIGIN_Y_RESET, 120);
      wait_for_replies();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grid_replies_due.size() == 0) begin
            $error("reply transaction with no reply outstanding");
            fail_count++;
         end else begin
            want = grid_replies_due.pop_front();
            check_field("was_updated", want.was_updated, rsp_data.was_updated);
            check_field("roi_min_x", want.roi_min_x, rsp_data.roi_min_x);
            check_field("roi_max_x", want.roi_max_x, rsp_data.roi_max_x);
            check_field("roi_min_y", want.roi_min_y, rsp_data.roi_min_y);
            check_field("roi_max_y", want.roi_max_y, rsp_data.roi_max_y);
            check_field("cell_height", want.cell_height, rsp_data.cell_height);
            check_field("cell_confidence", want.cell_confidence, rsp_data.cell_confidence);
         end
      end
   end

   // Reply back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

endmodule

[files.f]
design/egsu_pkg.sv
design/egsu_ram.sv
design/egsu_coord.sv
design/egsu_ctrl.sv
design/elevation_grid_splat_update.sv
design/egsu_checker.sv
tb/elevation_grid_splat_update_tb.sv
